>>> src/mmpc_pkg.sv
// Shared types, codes and helper functions for the meter map position converter.
package mmpc_pkg;

    localparam int POS_W  = 48;
    localparam int BEAT_W = 8;
    localparam int UNIT_W = 7;
    localparam int WIDE_W = 64;
    localparam int SEG_INDEX_W = 8;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int FRAC_BITS_DEF    = 16;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QTIME = 2'd2,
        OP_QBAR  = 2'd3
    } op_t;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // One segment table row
    typedef struct packed {
        logic signed [POS_W-1:0] quarter;
        logic signed [POS_W-1:0] bar;
        logic [BEAT_W-1:0]       beats;
        logic [UNIT_W-1:0]       unit;
    } row_t;

    localparam row_t ROW_RESET = '{quarter: '0, bar: '0, beats: 8'd4, unit: 7'd4};

    // Divider request and response
    typedef struct packed {
        logic                     start;
        logic signed [WIDE_W-1:0] dividend;
        logic [BEAT_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WIDE_W-1:0] quot;
        logic                     rem_nz;
    } div_rsp_t;

    localparam logic signed [WIDE_W-1:0] POS_MAX_W = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
    localparam logic signed [WIDE_W-1:0] POS_MIN_W = -POS_MAX_W - 64'sd1;

    // Round a beat unit down to a power of two, zero counts as one
    function automatic logic [UNIT_W-1:0] pow2_floor(input logic [UNIT_W-1:0] u);
        logic [UNIT_W-1:0] p;
        p = 7'd1;
        for (int i = 0; i < UNIT_W; i++) begin
            if (u[i])
            begin
                p = UNIT_W'(1 << i);
            end
        end
        return p;
    endfunction

    // Log2 of a power-of-two beat unit
    function automatic logic [2:0] unit_log2(input logic [UNIT_W-1:0] u);
        logic [2:0] l;
        l = 3'd0;
        for (int i = 0; i < UNIT_W; i++) begin
            if (u[i])
            begin
                l = 3'(i);
            end
        end
        return l;
    endfunction

    // Saturate a wide value to the signed position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v > POS_MAX_W)
        begin
            c = POS_MAX_W;
        end
        else if (v < POS_MIN_W)
        begin
            c = POS_MIN_W;
        end
        return c[POS_W-1:0];
    endfunction

endpackage

>>> src/mmpc_div.sv
// Bit-serial floor divider of a signed wide value by an unsigned 8-bit divisor.
module mmpc_div
    import mmpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(WIDE_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WIDE_W-1:0] a_reg;
    logic [WIDE_W-1:0] q_reg;
    logic [BEAT_W-1:0] rem_reg;
    logic [BEAT_W-1:0] b_reg;
    logic              neg_reg;

    logic [BEAT_W:0]   rem_sh;
    logic              ge;
    logic [BEAT_W:0]   rem_sub;
    logic [BEAT_W-1:0] rem_next;

    // One restoring step per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, a_reg[WIDE_W-1]};
        ge       = (rem_sh >= {1'b0, b_reg});
        rem_sub  = rem_sh - {1'b0, b_reg};
        rem_next = ge ? rem_sub[BEAT_W-1:0] : rem_sh[BEAT_W-1:0];
    end

    // Sequence the steps; a negative dividend divides its complement
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the datapath operands
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[WIDE_W-1];
            a_reg   <= req.dividend[WIDE_W-1] ? ~req.dividend : req.dividend;
            b_reg   <= req.divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= {a_reg[WIDE_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[WIDE_W-2:0], ge};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.quot   = neg_reg ? $signed(~q_reg) : $signed(q_reg);
    assign rsp.rem_nz = neg_reg ? (rem_reg != (b_reg - 1'b1)) : (rem_reg != '0);

endmodule

>>> src/meter_map_position_converter.sv
// Top level: segment table, label commit logic and query sequencer.
// Clear completes directly from idle; add label waits on the 64-step serial divider.
// Time query: one table read per search step, then the serial divider.
// Bar query time is set by the binary search table reads.
// One request at a time; the next is taken once the result has been taken.
// Reset (and clear) leave one segment {0, 0, 4, 4}; no table sweep is needed.
module meter_map_position_converter
    import mmpc_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               opcode,
    input  logic signed [POS_W-1:0]  position,
    input  logic [BEAT_W-1:0]        beats_per_bar,
    input  logic [UNIT_W-1:0]        beat_unit,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [POS_W-1:0]  converted,
    output logic [BEAT_W-1:0]        seg_beats,
    output logic [UNIT_W-1:0]        seg_unit,
    output logic [SEG_INDEX_W-1:0]   seg_index,
    output logic                     status
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [POS_W-1:0] FRAC_MASK = (48'd1 << FRAC_BITS) - 48'd1;
    localparam logic [5:0] SH_BASE = 6'(FRAC_BITS + 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_PREP,
        S_ADD_DIV,
        S_ADD_MUL,
        S_ADD_FIN,
        S_SRCH,
        S_CMP,
        S_Q_DATA,
        S_Q_MUL,
        S_Q_DIV,
        S_Q_FIN
    } state_t;

    state_t                   state_reg;
    op_t                      op_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic [BEAT_W-1:0]        beats_reg;
    logic [UNIT_W-1:0]        unit_reg;

    // Signature the label is measured against
    logic signed [POS_W-1:0]  cq_reg;
    logic signed [POS_W-1:0]  cb_reg;
    logic [BEAT_W-1:0]        cbeats_reg;
    logic [UNIT_W-1:0]        cunit_reg;
    logic                     lowrem_reg;
    logic signed [WIDE_W-1:0] kk_reg;
    logic signed [WIDE_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] diff_reg;

    // Committed and pending state
    logic signed [POS_W-1:0]  com_q_reg;
    logic signed [POS_W-1:0]  com_b_reg;
    logic [BEAT_W-1:0]        com_beats_reg;
    logic [UNIT_W-1:0]        com_unit_reg;
    logic signed [POS_W-1:0]  active_bar_reg;
    logic                     pend_valid_reg;
    logic signed [POS_W-1:0]  pend_q_reg;
    logic signed [POS_W-1:0]  pend_b_reg;
    logic [BEAT_W-1:0]        pend_beats_reg;
    logic [UNIT_W-1:0]        pend_unit_reg;
    logic [CNT_W-1:0]         seg_used_reg;
    logic                     row0_valid_reg;

    // Search state and found row
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic [IDX_W-1:0]         mid_reg;
    row_t                     srow_reg;

    // Result register
    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  conv_reg;
    logic [BEAT_W-1:0]        ob_reg;
    logic [UNIT_W-1:0]        ou_reg;
    logic [SEG_INDEX_W-1:0]   oi_reg;
    logic                     st_reg;

    // Table memory
    row_t                     mem [MAX_SEGMENTS];
    row_t                     rd_row_reg;
    logic                     rd_dflt_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    row_t                     mem_wdata;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     in_fire;
    logic [CNT_W-1:0]         mid_sum;
    logic [IDX_W-1:0]         mid;
    row_t                     row_eff;
    logic signed [POS_W-1:0]  key;

    logic                     use_pend;
    logic signed [POS_W-1:0]  sel_q;
    logic signed [POS_W-1:0]  sel_b;
    logic [BEAT_W-1:0]        sel_beats;
    logic [UNIT_W-1:0]        sel_unit;
    logic signed [POS_W-1:0]  lq;
    logic signed [WIDE_W-1:0] num;
    logic                     num_low_nz;

    logic signed [WIDE_W-1:0] bar_w;
    logic signed [WIDE_W-1:0] q_w;
    logic signed [POS_W-1:0]  bar_s;
    logic signed [POS_W-1:0]  q_s;
    logic                     advance;
    logic                     full;
    logic [CNT_W-1:0]         last_cnt;
    logic [IDX_W-1:0]         wr_idx;
    logic [5:0]               q_sh;
    logic signed [WIDE_W-1:0] q_time_w;
    logic signed [WIDE_W-1:0] q_bar_w;

    mmpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;

    // Search midpoint and read address
    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + CNT_W'(1);
        mid     = mid_sum[CNT_W-1:1];
        rd_addr = (lo_reg < hi_reg) ? mid : lo_reg;
        row_eff = rd_dflt_reg ? ROW_RESET : rd_row_reg;
        key     = (op_reg == OP_QTIME) ? row_eff.quarter : row_eff.bar;
    end

    // Snap the label to the bar grid of the chosen signature
    always_comb
    begin
        use_pend   = pend_valid_reg && (pos_reg > pend_q_reg);
        sel_q      = use_pend ? pend_q_reg : com_q_reg;
        sel_b      = use_pend ? pend_b_reg : com_b_reg;
        sel_beats  = use_pend ? pend_beats_reg : com_beats_reg;
        sel_unit   = use_pend ? pend_unit_reg : com_unit_reg;
        lq         = $signed(pos_reg & ~FRAC_MASK);
        num        = (WIDE_W'(lq) - WIDE_W'(sel_q)) <<< unit_log2(sel_unit);
        num_low_nz = (num[FRAC_BITS+1:0] != '0);
    end

    // Finish the label: bar, quarter and table decision
    always_comb
    begin
        q_sh      = SH_BASE - 6'(unit_log2(cunit_reg));
        bar_w     = WIDE_W'(cb_reg) + (kk_reg <<< FRAC_BITS);
        q_w       = WIDE_W'(cq_reg) + (prod_reg <<< q_sh);
        bar_s     = sat_pos(bar_w);
        q_s       = sat_pos(q_w);
        advance   = (bar_s > active_bar_reg);
        full      = (seg_used_reg >= CNT_W'(MAX_SEGMENTS));
        last_cnt  = seg_used_reg - CNT_W'(1);
        wr_idx    = advance ? seg_used_reg[IDX_W-1:0] : last_cnt[IDX_W-1:0];
        mem_we    = (state_reg == S_ADD_FIN) && !(advance && full);
        mem_waddr = wr_idx;
        mem_wdata = '{quarter: q_s, bar: bar_s, beats: beats_reg, unit: unit_reg};
    end

    // Query results
    always_comb
    begin
        q_time_w = WIDE_W'(srow_reg.bar) + prod_reg;
        q_bar_w  = WIDE_W'(srow_reg.quarter) + ((prod_reg <<< 2) >>> unit_log2(srow_reg.unit));
    end

    // Divider requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = num >>> (FRAC_BITS + 2);
        div_req.divisor  = sel_beats;
        if (state_reg == S_ADD_PREP)
        begin
            div_req.start = 1'b1;
        end
        else if ((state_reg == S_Q_MUL) && (op_reg == OP_QTIME))
        begin
            div_req.start    = 1'b1;
            div_req.dividend = (diff_reg <<< unit_log2(srow_reg.unit)) >>> 2;
            div_req.divisor  = srow_reg.beats;
        end
    end

    // Table memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_row_reg  <= mem[rd_addr];
        rd_dflt_reg <= (rd_addr == '0) && !(row0_valid_reg || (mem_we && (mem_waddr == '0)));
    end

    // Sequencer, state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            com_q_reg      <= '0;
            com_b_reg      <= '0;
            com_beats_reg  <= 8'd4;
            com_unit_reg   <= 7'd4;
            active_bar_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_q_reg     <= '0;
            pend_b_reg     <= '0;
            pend_beats_reg <= '0;
            pend_unit_reg  <= '0;
            seg_used_reg   <= CNT_W'(1);
            row0_valid_reg <= 1'b0;
            op_reg         <= OP_CLEAR;
            lo_reg         <= '0;
            hi_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg    <= op_t'(opcode);
                        pos_reg   <= position;
                        beats_reg <= (beats_per_bar == '0) ? 8'd1 : beats_per_bar;
                        unit_reg  <= pow2_floor(beat_unit);
                        lo_reg    <= '0;
                        hi_reg    <= last_cnt[IDX_W-1:0];
                        unique case (op_t'(opcode))
                            OP_CLEAR:
                            begin
                                com_q_reg      <= '0;
                                com_b_reg      <= '0;
                                com_beats_reg  <= 8'd4;
                                com_unit_reg   <= 7'd4;
                                active_bar_reg <= '0;
                                pend_valid_reg <= 1'b0;
                                pend_q_reg     <= '0;
                                pend_b_reg     <= '0;
                                pend_beats_reg <= '0;
                                pend_unit_reg  <= '0;
                                seg_used_reg   <= CNT_W'(1);
                                row0_valid_reg <= 1'b0;
                                conv_reg       <= '0;
                                ob_reg         <= 8'd4;
                                ou_reg         <= 7'd4;
                                oi_reg         <= '0;
                                st_reg         <= ST_OK;
                                out_valid_reg  <= 1'b1;
                            end
                            OP_ADD:
                            begin
                                state_reg <= S_ADD_PREP;
                            end
                            default:
                            begin
                                state_reg <= S_SRCH;
                            end
                        endcase
                    end
                end
                S_ADD_PREP:
                begin
                    cq_reg     <= sel_q;
                    cb_reg     <= sel_b;
                    cbeats_reg <= sel_beats;
                    cunit_reg  <= sel_unit;
                    lowrem_reg <= num_low_nz;
                    state_reg  <= S_ADD_DIV;
                end
                S_ADD_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        kk_reg    <= div_rsp.quot
                                   + WIDE_W'(lowrem_reg || div_rsp.rem_nz);
                        state_reg <= S_ADD_MUL;
                    end
                end
                S_ADD_MUL:
                begin
                    prod_reg  <= kk_reg * $signed({1'b0, cbeats_reg});
                    state_reg <= S_ADD_FIN;
                end
                S_ADD_FIN:
                begin
                    conv_reg      <= q_s;
                    ob_reg        <= beats_reg;
                    ou_reg        <= unit_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                    if (advance && full)
                    begin
                        st_reg <= ST_FULL;
                        oi_reg <= SEG_INDEX_W'(last_cnt[IDX_W-1:0]);
                    end
                    else
                    begin
                        st_reg         <= ST_OK;
                        oi_reg         <= SEG_INDEX_W'(wr_idx);
                        if (advance)
                        begin
                            seg_used_reg <= seg_used_reg + CNT_W'(1);
                        end
                        if (wr_idx == '0)
                        begin
                            row0_valid_reg <= 1'b1;
                        end
                        com_q_reg      <= cq_reg;
                        com_b_reg      <= cb_reg;
                        com_beats_reg  <= cbeats_reg;
                        com_unit_reg   <= cunit_reg;
                        pend_valid_reg <= 1'b1;
                        pend_q_reg     <= q_s;
                        pend_b_reg     <= bar_s;
                        pend_beats_reg <= beats_reg;
                        pend_unit_reg  <= unit_reg;
                        active_bar_reg <= bar_s;
                    end
                end
                S_SRCH:
                begin
                    mid_reg   <= mid;
                    state_reg <= (lo_reg < hi_reg) ? S_CMP : S_Q_DATA;
                end
                S_CMP:
                begin
                    if (key <= pos_reg)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg - 1'b1;
                    end
                    state_reg <= S_SRCH;
                end
                S_Q_DATA:
                begin
                    srow_reg  <= row_eff;
                    diff_reg  <= WIDE_W'(pos_reg) - WIDE_W'(key);
                    state_reg <= S_Q_MUL;
                end
                S_Q_MUL:
                begin
                    if (op_reg == OP_QTIME)
                    begin
                        state_reg <= S_Q_DIV;
                    end
                    else
                    begin
                        prod_reg  <= diff_reg * $signed({1'b0, srow_reg.beats});
                        state_reg <= S_Q_FIN;
                    end
                end
                S_Q_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        prod_reg  <= div_rsp.quot;
                        state_reg <= S_Q_FIN;
                    end
                end
                S_Q_FIN:
                begin
                    conv_reg      <= (op_reg == OP_QTIME) ? sat_pos(q_time_w)
                                                          : sat_pos(q_bar_w);
                    ob_reg        <= srow_reg.beats;
                    ou_reg        <= srow_reg.unit;
                    oi_reg        <= SEG_INDEX_W'(lo_reg);
                    st_reg        <= ST_OK;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign converted = conv_reg;
    assign seg_beats = ob_reg;
    assign seg_unit  = ou_reg;
    assign seg_index = oi_reg;
    assign status    = st_reg;

endmodule
